@@ hw/rtl/wtv_pkg.sv @@
// Shared types, constants and waveform/envelope tables for the wavetable voice.
// Used by wtv_ctrl, wtv_datapath and wavetable_voice_with_envelope_core.
// No dependencies.
package wtv_pkg;

    localparam int WAVE_LEN   = 64;
    localparam int ENV_STEPS  = 16;
    localparam int POS_W      = $clog2(WAVE_LEN);
    localparam int STEP_W     = $clog2(ENV_STEPS);
    localparam int ROM_W      = 11;
    localparam int SUM_W      = 14;
    localparam int DIV_STEPS  = SUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int ENVCNT_W   = 13;
    localparam int SUST_W     = 12;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_NOTE = 2'd1;
    localparam logic [1:0] CMD_PLAY = 2'd2;

    localparam logic       CFG_MASK  = 1'b0;
    localparam logic       CFG_TEMPO = 1'b1;

    localparam logic [4:0]        MASK_RESET    = 5'd1;
    localparam logic [SUST_W-1:0] SUSTAIN_NOTE  = 12'h3FF;
    localparam logic [SUST_W-1:0] SUSTAIN_RESET = 12'hFFF;

    localparam longint CLOCK_HZ      = 80000000;
    localparam longint BEATS_PER_MIN = 250;
    localparam longint BEAT_SCALE    = 30;
    localparam logic [31:0] NOTE_CYCLES = 32'(CLOCK_HZ / BEATS_PER_MIN * BEAT_SCALE);

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_needed;
    } t_ctrl_stat;

    localparam logic [ROM_W-1:0] ROM_FLUTE [WAVE_LEN] = '{
        11'd1007,11'd1252,11'd1374,11'd1548,11'd1698,11'd1797,11'd1825,11'd1797,
        11'd1675,11'd1562,11'd1383,11'd1219,11'd1092,11'd1007,11'd913, 11'd890,
        11'd833, 11'd847, 11'd810, 11'd777, 11'd744, 11'd674, 11'd598, 11'd551,
        11'd509, 11'd476, 11'd495, 11'd533, 11'd589, 11'd659, 11'd758, 11'd876,
        11'd1007,11'd1252,11'd1374,11'd1548,11'd1698,11'd1797,11'd1825,11'd1797,
        11'd1675,11'd1562,11'd1383,11'd1219,11'd1092,11'd1007,11'd913, 11'd890,
        11'd833, 11'd847, 11'd810, 11'd777, 11'd744, 11'd674, 11'd598, 11'd551,
        11'd509, 11'd476, 11'd495, 11'd533, 11'd589, 11'd659, 11'd758, 11'd876};

    localparam logic [ROM_W-1:0] ROM_HORN [WAVE_LEN] = '{
        11'd1063,11'd1082,11'd1119,11'd1275,11'd1678,11'd1748,11'd1275,11'd755,
        11'd661, 11'd661, 11'd703, 11'd731, 11'd769, 11'd845, 11'd1039,11'd1134,
        11'd1209,11'd1332,11'd1465,11'd1545,11'd1427,11'd1588,11'd1370,11'd1086,
        11'd708, 11'd519, 11'd448, 11'd490, 11'd566, 11'd684, 11'd802, 11'd992,
        11'd1063,11'd1082,11'd1119,11'd1275,11'd1678,11'd1748,11'd1275,11'd755,
        11'd661, 11'd661, 11'd703, 11'd731, 11'd769, 11'd845, 11'd1039,11'd1134,
        11'd1209,11'd1332,11'd1465,11'd1545,11'd1427,11'd1588,11'd1370,11'd1086,
        11'd708, 11'd519, 11'd448, 11'd490, 11'd566, 11'd684, 11'd802, 11'd992};

    localparam logic [ROM_W-1:0] ROM_SINE [WAVE_LEN] = '{
        11'd1024,11'd1122,11'd1215,11'd1302,11'd1378,11'd1440,11'd1486,11'd1514,
        11'd1524,11'd1514,11'd1486,11'd1440,11'd1378,11'd1302,11'd1215,11'd1122,
        11'd1024,11'd926, 11'd833, 11'd746, 11'd670, 11'd608, 11'd562, 11'd534,
        11'd524, 11'd534, 11'd562, 11'd608, 11'd670, 11'd746, 11'd833, 11'd926,
        11'd1024,11'd1122,11'd1215,11'd1302,11'd1378,11'd1440,11'd1486,11'd1514,
        11'd1524,11'd1514,11'd1486,11'd1440,11'd1378,11'd1302,11'd1215,11'd1122,
        11'd1024,11'd926, 11'd833, 11'd746, 11'd670, 11'd608, 11'd562, 11'd534,
        11'd524, 11'd534, 11'd562, 11'd608, 11'd670, 11'd746, 11'd833, 11'd926};

    localparam logic [ROM_W-1:0] ROM_TRUMPET [WAVE_LEN] = '{
        11'd1007,11'd1088,11'd1156,11'd1194,11'd1067,11'd789, 11'd303, 11'd99,
        11'd789, 11'd1510,11'd1476,11'd1173,11'd1067,11'd1037,11'd1084,11'd1062,
        11'd1011,11'd1015,11'd1045,11'd1062,11'd1011,11'd1011,11'd1058,11'd1113,
        11'd1084,11'd1075,11'd1079,11'd1105,11'd1088,11'd1049,11'd1015,11'd1045,
        11'd1007,11'd1088,11'd1156,11'd1194,11'd1067,11'd789, 11'd303, 11'd99,
        11'd789, 11'd1510,11'd1476,11'd1173,11'd1067,11'd1037,11'd1084,11'd1062,
        11'd1011,11'd1015,11'd1045,11'd1062,11'd1011,11'd1011,11'd1058,11'd1113,
        11'd1084,11'd1075,11'd1079,11'd1105,11'd1088,11'd1049,11'd1015,11'd1045};

    localparam logic [ROM_W-1:0] ROM_GUITAR [WAVE_LEN] = '{
        11'd1024,11'd1024,11'd1026,11'd1001,11'd935, 11'd833, 11'd730, 11'd647,
        11'd619, 11'd666, 11'd782, 11'd964, 11'd1172,11'd1337,11'd1461,11'd1536,
        11'd1558,11'd1503,11'd1396,11'd1235,11'd1040,11'd864, 11'd755, 11'd758,
        11'd877, 11'd1087,11'd1358,11'd1613,11'd1789,11'd1846,11'd1772,11'd1625,
        11'd1454,11'd1285,11'd1173,11'd1096,11'd1052,11'd1034,11'd1027,11'd1036,
        11'd1079,11'd1137,11'd1184,11'd1247,11'd1264,11'd1250,11'd1182,11'd1081,
        11'd974, 11'd865, 11'd801, 11'd779, 11'd810, 11'd844, 11'd859, 11'd859,
        11'd851, 11'd849, 11'd875, 11'd922, 11'd977, 11'd1024,11'd1024,11'd1024};

    localparam logic [ROM_W-1:0] ROM_DECAY [ENV_STEPS] = '{
        11'd1,  11'd1,  11'd2,  11'd4,  11'd7,   11'd12,  11'd20,  11'd33,
        11'd54, 11'd90, 11'd148,11'd244,11'd403, 11'd665, 11'd1096,11'd1808};

    // Sum of the enabled waveforms at one position.
    function automatic logic [SUM_W-1:0] mix_sum(input logic [4:0] mask,
                                                 input logic [POS_W-1:0] pos);
        logic [SUM_W-1:0] s;
        s = '0;
        if (mask[0]) s = s + SUM_W'(ROM_FLUTE[pos]);
        if (mask[1]) s = s + SUM_W'(ROM_HORN[pos]);
        if (mask[2]) s = s + SUM_W'(ROM_SINE[pos]);
        if (mask[3]) s = s + SUM_W'(ROM_TRUMPET[pos]);
        if (mask[4]) s = s + SUM_W'(ROM_GUITAR[pos]);
        return s;
    endfunction

endpackage

@@ hw/rtl/wtv_ctrl.sv @@
// Sequencer for the wavetable voice: input handshake, divider iteration count,
// output register handshake. Depends on wtv_pkg.
module wtv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  wtv_pkg::t_ctrl_stat  i_stat,
    output wtv_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [wtv_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.div_needed ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == wtv_pkg::CNT_W'(wtv_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hw/rtl/wtv_datapath.sv @@
// Datapath of the wavetable voice: voice state, mixer, restoring divider,
// note-length multiplier, config registers and output payload. Depends on wtv_pkg.
module wtv_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wtv_pkg::t_ctrl_cmd   i_cmd_ctl,
    output wtv_pkg::t_ctrl_stat  o_stat,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [4:0]           i_cfg_data,
    input  logic [1:0]           i_cmd,
    input  logic [15:0]          i_note_period,
    input  logic [7:0]           i_note_length,
    output logic [13:0]          o_dac_value,
    output logic                 o_tone_load,
    output logic [15:0]          o_tone_reload,
    output logic                 o_note_taken,
    output logic [31:0]          o_note_reload,
    output logic                 o_playing_now
);

    localparam int PW = wtv_pkg::POS_W;
    localparam int SW = wtv_pkg::STEP_W;
    localparam int RW = wtv_pkg::ROM_W;
    localparam int QW = wtv_pkg::SUM_W;
    localparam int EW = wtv_pkg::ENVCNT_W;
    localparam int LW = wtv_pkg::SUST_W;

    logic [4:0]    r_mask;
    logic          r_tempo;
    logic          r_playing, n_playing;
    logic          r_sound_on, n_sound_on;
    logic [PW-1:0] r_wave_pos, n_wave_pos;
    logic [SW-1:0] r_env_step, n_env_step;
    logic [EW-1:0] r_env_count, n_env_count;
    logic [LW-1:0] r_sustain, n_sustain;

    logic [1:0]    r_cmd;
    logic [15:0]   r_period;
    logic [RW-1:0] r_divisor;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [31:0]   r_prod;

    logic [RW:0]   div_try;
    logic          div_ge;

    logic [QW-1:0] n_dac;
    logic          n_tload;
    logic [15:0]   n_treload;
    logic          n_taken;
    logic [31:0]   n_nreload;

    assign o_stat.div_needed = (i_cmd == wtv_pkg::CMD_TICK) && r_sound_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= wtv_pkg::MASK_RESET;
            r_tempo <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wtv_pkg::CFG_MASK:  r_mask  <= i_cfg_data;
                wtv_pkg::CFG_TEMPO: r_tempo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign div_try = {r_rem, r_quo[QW-1]};
    assign div_ge  = div_try >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd     <= i_cmd;
            r_period  <= i_note_period;
            r_quo     <= wtv_pkg::mix_sum(r_mask, r_wave_pos);
            r_divisor <= wtv_pkg::ROM_DECAY[r_env_step];
            r_rem     <= '0;
            r_prod    <= 32'(i_note_length) * wtv_pkg::NOTE_CYCLES;
        end else if (i_cmd_ctl.step) begin
            r_rem <= div_ge ? RW'(div_try - {1'b0, r_divisor}) : div_try[RW-1:0];
            r_quo <= {r_quo[QW-2:0], div_ge};
        end
    end

    always_comb begin
        n_playing   = r_playing;
        n_sound_on  = r_sound_on;
        n_wave_pos  = r_wave_pos;
        n_env_step  = r_env_step;
        n_env_count = r_env_count;
        n_sustain   = r_sustain;
        n_dac       = '0;
        n_tload     = 1'b0;
        n_treload   = '0;
        n_taken     = 1'b0;
        n_nreload   = '0;
        unique case (r_cmd)
            wtv_pkg::CMD_TICK: begin
                if (r_sound_on) begin
                    n_dac = r_quo;
                    if (r_env_count > EW'(r_sustain)) begin
                        if (r_env_step != '1) begin
                            n_env_step = r_env_step + 1'b1;
                        end
                        n_env_count = '0;
                    end else begin
                        n_env_count = r_env_count + 1'b1;
                    end
                    n_wave_pos = r_wave_pos + 1'b1;
                end
            end
            wtv_pkg::CMD_NOTE: begin
                if (!r_playing) begin
                    n_sound_on = 1'b0;
                end else begin
                    n_taken     = 1'b1;
                    n_env_step  = '0;
                    n_env_count = '0;
                    n_sustain   = wtv_pkg::SUSTAIN_NOTE;
                    if (r_period == '0) begin
                        n_sound_on = 1'b0;
                    end else begin
                        n_sound_on = 1'b1;
                        n_tload    = 1'b1;
                        n_treload  = r_period;
                    end
                    n_nreload = r_tempo ? {1'b0, r_prod[31:1]} : r_prod;
                end
            end
            wtv_pkg::CMD_PLAY: begin
                n_playing  = !r_playing;
                n_sound_on = !r_playing;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing   <= 1'b0;
            r_sound_on  <= 1'b0;
            r_wave_pos  <= '0;
            r_env_step  <= '0;
            r_env_count <= '0;
            r_sustain   <= wtv_pkg::SUSTAIN_RESET;
        end else if (i_cmd_ctl.finish) begin
            r_playing   <= n_playing;
            r_sound_on  <= n_sound_on;
            r_wave_pos  <= n_wave_pos;
            r_env_step  <= n_env_step;
            r_env_count <= n_env_count;
            r_sustain   <= n_sustain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.finish) begin
            o_dac_value   <= n_dac;
            o_tone_load   <= n_tload;
            o_tone_reload <= n_treload;
            o_note_taken  <= n_taken;
            o_note_reload <= n_nreload;
            o_playing_now <= n_playing;
        end
    end

endmodule

@@ hw/rtl/wavetable_voice_with_envelope_core.sv @@
// Top level of the wavetable synthesizer voice with decay envelope.
// Instantiates wtv_ctrl and wtv_datapath; depends on wtv_pkg.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one command: sample tick, note
//   start or play toggle, with note period and length. Output channel
//   (o_valid/i_ready) returns exactly one result per command.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 instrument mask, 1 tempo double); write only while idle.
// Sequence:
//   A sample tick with sound on: the input transfer loads the operands, the
//   bit-serial divider runs 14 steps, and one write fills the output register
//   once it is free. Other commands skip the divider. In every case o_ready
//   returns in the same cycle as o_valid rises.
//   One item is in work at a time.
// Reset:
//   Synchronous active-low; stops play, mutes, clears position and envelope,
//   sustain limit 4095, instrument mask 1, tempo normal.
// Stall:
//   While i_ready holds the output register, one more command is taken and
//   worked; its result then waits in the datapath and o_ready stays low.
module wavetable_voice_with_envelope_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_cmd,
    input  logic [15:0]  i_note_period,
    input  logic [7:0]   i_note_length,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [13:0]  o_dac_value,
    output logic         o_tone_load,
    output logic [15:0]  o_tone_reload,
    output logic         o_note_taken,
    output logic [31:0]  o_note_reload,
    output logic         o_playing_now,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [4:0]   i_cfg_data
);

    wtv_pkg::t_ctrl_cmd  ctl_cmd;
    wtv_pkg::t_ctrl_stat ctl_stat;

    wtv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (ctl_stat),
        .o_cmd   (ctl_cmd)
    );

    wtv_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ctl     (ctl_cmd),
        .o_stat        (ctl_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_note_period (i_note_period),
        .i_note_length (i_note_length),
        .o_dac_value   (o_dac_value),
        .o_tone_load   (o_tone_load),
        .o_tone_reload (o_tone_reload),
        .o_note_taken  (o_note_taken),
        .o_note_reload (o_note_reload),
        .o_playing_now (o_playing_now)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while previous command in work");

    a_tick_excl_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dac_value != '0) |-> (!o_note_taken && !o_tone_load))
        else $error("sample and note fields in one result");

    a_taken_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_note_taken) |-> o_playing_now)
        else $error("note taken while stopped");

    a_load_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tone_load) |-> (o_note_taken && o_tone_reload != '0))
        else $error("tone load without accepted note");

endmodule
